>>> rtl/assert_macros.svh
// Concurrent assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property that must hold at every clock edge out of reset.
`define OSLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define OSLB_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

>>> rtl/oslb_pkg.sv
`timescale 1ns / 1ps
package oslb_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_W        = 32;
  localparam int FANIN_LG     = 4;
  localparam int FANIN        = 1 << FANIN_LG;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOWER  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_MISSING   = 3'd4,
    ST_FOUND     = 3'd5,
    ST_NONE      = 3'd6
  } status_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    occ;
    logic                    lt;
  } cell_link_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                    add_en;
    logic                    rem_en;
    logic signed [KEY_W-1:0] probe;
  } cell_op_t;

  // One node of the result reduction tree.
  typedef struct packed {
    logic             hit;
    logic             found;
    logic [KEY_W-1:0] bound;
  } node_t;

  // Number of registered tree levels to cover n leaves.
  function automatic int tree_levels(int n);
    int lvl;
    int span;
    lvl  = 1;
    span = FANIN;
    for (int s = 0; s < 8; s++) begin
      if (span < n) begin
        span = span * FANIN;
        lvl  = lvl + 1;
      end
    end
    return lvl;
  endfunction

endpackage

>>> rtl/oslb_cell.sv
`timescale 1ns / 1ps
module oslb_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  oslb_pkg::cell_op_t   op_i,
  input  oslb_pkg::cell_link_t left_i,
  input  oslb_pkg::cell_link_t right_i,
  output oslb_pkg::cell_link_t link_o,
  output oslb_pkg::node_t      leaf_o
);
  import oslb_pkg::*;

  logic signed [KEY_W-1:0] key_r;
  logic                    occ_r;
  logic                    lt;
  logic                    hit;
  logic                    bnd;

  assign lt  = occ_r && (key_r < op_i.probe);
  assign hit = occ_r && (key_r == op_i.probe);
  // first occupied slot not below the probe
  assign bnd = occ_r && !lt && left_i.lt;

  assign link_o = '{key: key_r, occ: occ_r, lt: lt};
  assign leaf_o = '{hit: hit, found: bnd, bound: bnd ? key_r : '0};

  always_ff @(posedge clk) begin
    if (op_i.add_en && !lt) begin
      key_r <= left_i.lt ? op_i.probe : left_i.key;
    end else if (op_i.rem_en && !lt) begin
      key_r <= right_i.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (op_i.add_en && !lt) begin
      occ_r <= left_i.lt ? 1'b1 : left_i.occ;
    end else if (op_i.rem_en && !lt) begin
      occ_r <= right_i.occ;
    end
  end

endmodule

>>> rtl/oslb_reduce.sv
`timescale 1ns / 1ps
module oslb_reduce #(
  parameter int N = oslb_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  oslb_pkg::node_t leaves_i [N],
  output oslb_pkg::node_t root_o
);
  import oslb_pkg::*;

  localparam int LEVELS = tree_levels(N);
  localparam int PAD    = 1 << (FANIN_LG * LEVELS);

  node_t leaf [PAD];
  node_t tree_r [1:LEVELS][PAD];

  for (genvar j = 0; j < PAD; j++) begin : g_leaf
    if (j < N) begin : g_real
      assign leaf[j] = leaves_i[j];
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < PAD; j++) begin : g_node
      if (j < (PAD >> (FANIN_LG * l))) begin : g_used
        node_t sum_c;
        if (l == 1) begin : g_first
          always_comb begin
            sum_c = '0;
            for (int k = 0; k < FANIN; k++) begin
              sum_c = node_t'(sum_c | leaf[j*FANIN + k]);
            end
          end
        end else begin : g_upper
          always_comb begin
            sum_c = '0;
            for (int k = 0; k < FANIN; k++) begin
              sum_c = node_t'(sum_c | tree_r[l-1][j*FANIN + k]);
            end
          end
        end
        always_ff @(posedge clk) begin
          tree_r[l][j] <= sum_c;
        end
      end else begin : g_tie
        always_ff @(posedge clk) begin
          tree_r[l][j] <= '0;
        end
      end
    end
  end

  assign root_o = tree_r[LEVELS][0];

endmodule

>>> rtl/ordered_set_lower_bound.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Ordered set of distinct signed 32-bit keys with add, remove and lower-bound requests.
// Input channel: in_tvalid/in_tready carry one request; in_tuser holds the command
// (0 add, 1 remove, 2 lower bound), in_tdata the key or probe. Command 3 is dropped
// with no result. Output channel: out_tuser holds the status, out_tdata the bound key
// (zero unless the status is bound found).
// The keys sit in a row of CAPACITY cells, sorted ascending, occupied slots forming a
// prefix. Every cell compares its key against the broadcast probe; an add shifts the
// cells at and above the insert point up by one, a remove shifts them down, each cell
// taking its neighbor's key, all in the same cycle.
// Duplicate / hit / bound flags are gathered by a registered 16-ary OR tree of
// L = ceil(log16(CAPACITY)) levels, at least one (L = 2 for 256 slots). A request
// passes through the accept cycle in the idle state, the evaluate state while the
// tree levels register, and the apply state that updates the cells and loads the
// result; apply waits while the output register is held. Only one request is in flight at a time.
// Reset (synchronous, active low) empties every slot at once; no clearing pass is
// needed and in_tready is high in the first cycle after reset.
// The result sits in an output register; a stalled receiver holds it, the next request
// is still accepted and evaluated, and only its apply cycle waits for the register.
module ordered_set_lower_bound #(
  parameter int CAPACITY = oslb_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] bound_key
  output logic [2:0]  out_tuser   // [2:0] status
);
  import oslb_pkg::*;

  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int CNT_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic signed [KEY_W-1:0] probe_r, probe_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 status_r, status_nxt;
  logic [KEY_W-1:0]        bound_r, bound_nxt;

  logic       in_fire;
  logic       cmd_ok;
  logic       apply_go;
  logic       full;
  status_t    status_c;
  logic [KEY_W-1:0] bound_c;
  cell_op_t   op;
  node_t      root;
  node_t      leaves [CAPACITY];
  cell_link_t link [CAPACITY];
  cell_link_t head_link;
  cell_link_t tail_link;
  logic [CAPACITY-1:0] occ_vec;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cmd_ok     = (in_tuser == CMD_ADD) || (in_tuser == CMD_REMOVE) ||
                      (in_tuser == CMD_LOWER);
  // hold the apply step until the output register is free
  assign apply_go   = (state_r == S_APPLY) && (!out_valid_r || out_tready);
  assign full       = link[CAPACITY-1].occ;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = bound_r;
  assign out_tuser  = status_r;

  // Edges of the row: below slot 0 everything counts as smaller, above the top slot empty.
  assign head_link = '{key: '0, occ: 1'b1, lt: 1'b1};
  assign tail_link = '{key: '0, occ: 1'b0, lt: 1'b0};

  assign op.probe  = probe_r;
  assign op.add_en = apply_go && (cmd_r == CMD_ADD) && !root.hit && !full;
  assign op.rem_en = apply_go && (cmd_r == CMD_REMOVE) && root.hit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left_c;
    cell_link_t right_c;
    if (i == 0) begin : g_head
      assign left_c = head_link;
    end else begin : g_left
      assign left_c = link[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_c = tail_link;
    end else begin : g_right
      assign right_c = link[i+1];
    end
    oslb_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .op_i   (op),
      .left_i (left_c),
      .right_i(right_c),
      .link_o (link[i]),
      .leaf_o (leaves[i])
    );
    assign occ_vec[i] = link[i].occ;
  end

  oslb_reduce #(
    .N(CAPACITY)
  ) u_reduce (
    .clk     (clk),
    .leaves_i(leaves),
    .root_o  (root)
  );

  // Result of the request under evaluation, valid in the apply state.
  always_comb begin
    bound_c = '0;
    case (cmd_r)
      CMD_ADD: begin
        if (root.hit) begin
          status_c = ST_DUPLICATE;
        end else if (full) begin
          status_c = ST_FULL;
        end else begin
          status_c = ST_ADDED;
        end
      end
      CMD_REMOVE: begin
        status_c = root.hit ? ST_REMOVED : ST_MISSING;
      end
      CMD_LOWER: begin
        if (root.found) begin
          status_c = ST_FOUND;
          bound_c  = root.bound;
        end else begin
          status_c = ST_NONE;
        end
      end
      default: begin
        status_c = ST_NONE;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    probe_nxt     = probe_r;
    status_nxt    = status_r;
    bound_nxt     = bound_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        // latch the request; drop the unused command code here
        if (in_fire) begin
          cmd_nxt   = cmd_t'(in_tuser);
          probe_nxt = in_tdata;
          cnt_nxt   = '0;
          if (cmd_ok) begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        // advance until the tree root reflects the latched probe
        if (cnt_r == CNT_W'(LEVELS - 1)) begin
          state_nxt = S_APPLY;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_APPLY: begin
        if (apply_go) begin
          status_nxt    = status_c;
          bound_nxt     = bound_c;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    probe_r  <= probe_nxt;
    status_r <= status_nxt;
    bound_r  <= bound_nxt;
  end

  `OSLB_ASSERT(a_occ_prefix, ((occ_vec >> 1) & ~occ_vec) == '0, "occupied slots not a prefix")
  `OSLB_ASSERT(a_valid_from_apply, $rose(out_tvalid) |-> $past(state_r == S_APPLY), "result without apply")
  `OSLB_ASSERT_NEXT(a_apply_loads, apply_go, out_tvalid, "apply did not load result")
  `OSLB_ASSERT_NEXT(a_accept_eval, in_fire && cmd_ok, state_r == S_EVAL, "accepted request not evaluated")
  `OSLB_ASSERT(a_bound_zero, (out_tvalid && (out_tuser != ST_FOUND)) |-> (out_tdata == '0), "bound key set without bound")

endmodule
